[sv/shuffled_lcg_random_generator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the shuffled LCG random generator
// Concurrent checks clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_LCG_RANDOM_GENERATOR_ASSERT_SVH
`define SHUFFLED_LCG_RANDOM_GENERATOR_ASSERT_SVH

// same-cycle implication
`define SRG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("srg: same-cycle check failed");

// next-cycle implication
`define SRG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("srg: next-cycle check failed");

`endif

[sv/srg_pkg.sv]
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types and constants of the shuffled LCG random generator.
// ----------------------------------------------------------------------------
package srg_pkg;

    localparam logic [30:0] LCG_MOD       = 31'h7FFF_FFFF;
    localparam logic [14:0] LCG_MUL       = 15'd16807;
    localparam logic [30:0] SAT_LIMIT     = 31'd2147483389;
    localparam int          WARMUP_EXTRA  = 8;

    typedef struct packed {
        logic        warm;
        logic [30:0] start;
    } req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

[sv/srg_front.sv]
// ----------------------------------------------------------------------------
// srg_front
// Accepts requests and classifies them as plain draws or warm-up draws.
// ----------------------------------------------------------------------------
module srg_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_reseed,
    input  logic [30:0]        seed_value,
    output logic               push_valid,
    input  logic               push_ready,
    output srg_pkg::req_t      push_data
);

    logic        init_reg;
    logic        init_next;
    logic [30:0] seed_fixed;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    assign seed_fixed = ((seed_value == srg_pkg::LCG_MOD) || (seed_value == 31'd0))
                        ? 31'd1 : seed_value;

    always_comb begin
        push_data.warm  = s_reseed || !init_reg;
        push_data.start = s_reseed ? seed_fixed : 31'd1;
        init_next       = init_reg || (s_valid && push_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= 1'b0;
        end else begin
            init_reg <= init_next;
        end
    end

endmodule

[sv/srg_queue.sv]
// ----------------------------------------------------------------------------
// srg_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module srg_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  srg_pkg::req_t      in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output srg_pkg::req_t      out_data,
    output srg_pkg::qstat_t    status
);

    srg_pkg::req_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;
    logic          pop;

    assign in_ready     = (count_reg != 2'd2);
    assign out_valid    = (count_reg != 2'd0);
    assign out_data     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/srg_back.sv]
// ----------------------------------------------------------------------------
// srg_back
// Runs warm-up and shuffled draws: shared multiply-mod unit, shuffle table
// memory, index divider and output register.
// ----------------------------------------------------------------------------
module srg_back #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               req_valid,
    output logic               req_ready,
    input  srg_pkg::req_t      req_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [30:0]        m_sample,
    output logic               m_saturated,
    output logic               busy
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + srg_pkg::WARMUP_EXTRA);
    localparam longint unsigned DIVISOR = 64'd1 + (64'd2147483646 / TABLE_ENTRIES);
    localparam longint unsigned RECIP   = (64'd1 << 40) / DIVISOR;
    localparam logic [30:0] DIV_C   = 31'(DIVISOR);
    localparam logic [15:0] RECIP_C = 16'(RECIP);
    localparam logic [CNT_W-1:0] CNT_START =
        CNT_W'(TABLE_ENTRIES + srg_pkg::WARMUP_EXTRA - 1);
    localparam logic [CNT_W-1:0] CNT_TABLE = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [6:0] Q_LIMIT = 7'(TABLE_ENTRIES);
    localparam logic [6:0] Q_LAST  = 7'(TABLE_ENTRIES - 1);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b000_0001,
        ST_WARM_MUL = 7'b000_0010,
        ST_WARM_RED = 7'b000_0100,
        ST_DRAW_MUL = 7'b000_1000,
        ST_DRAW_RED = 7'b001_0000,
        ST_DRAW_IDX = 7'b010_0000,
        ST_DRAW_WR  = 7'b100_0000
    } state_t;

    logic [30:0]      table_mem [TABLE_ENTRIES];

    state_t           state_reg,     state_next;
    logic [CNT_W-1:0] cnt_reg,       cnt_next;
    logic [30:0]      lcg_reg,       lcg_next;
    logic [30:0]      last_reg,      last_next;
    logic [45:0]      prod_reg,      prod_next;
    logic [6:0]       q0_reg,        q0_next;
    logic [30:0]      qd_reg,        qd_next;
    logic [IDX_W-1:0] idx_reg,       idx_next;
    logic [30:0]      rd_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic [30:0]      sample_reg,    sample_next;
    logic             sat_reg,       sat_next;

    logic [31:0]      fold_sum;
    logic [30:0]      reduced;
    logic [46:0]      recip_prod;
    logic [30:0]      rem;
    logic [6:0]       q_fix;
    logic [IDX_W-1:0] idx_sel;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [30:0]      wr_data;

    assign m_valid     = out_valid_reg;
    assign m_sample    = sample_reg;
    assign m_saturated = sat_reg;
    assign busy        = (state_reg != ST_IDLE);

    always_comb begin
        fold_sum   = {17'd0, prod_reg[45:31]} + {1'b0, prod_reg[30:0]};
        reduced    = (fold_sum >= {1'b0, srg_pkg::LCG_MOD})
                     ? 31'(fold_sum - {1'b0, srg_pkg::LCG_MOD}) : fold_sum[30:0];
        recip_prod = 47'(last_reg) * 47'(RECIP_C);
        rem        = last_reg - qd_reg;
        q_fix      = q0_reg + 7'(rem >= DIV_C);
        idx_sel    = (q_fix >= Q_LIMIT) ? Q_LAST[IDX_W-1:0] : q_fix[IDX_W-1:0];
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        lcg_next       = lcg_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        q0_next        = q0_reg;
        qd_next        = qd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        sample_next    = sample_reg;
        sat_next       = sat_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = lcg_reg;
        req_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    if (req_data.warm) begin
                        lcg_next   = req_data.start;
                        cnt_next   = CNT_START;
                        state_next = ST_WARM_MUL;
                    end else begin
                        state_next = ST_DRAW_MUL;
                    end
                end
            end
            ST_WARM_MUL: begin
                prod_next  = 46'(lcg_reg) * 46'(srg_pkg::LCG_MUL);
                state_next = ST_WARM_RED;
            end
            ST_WARM_RED: begin
                lcg_next = reduced;
                if (cnt_reg < CNT_TABLE) begin
                    wr_en   = 1'b1;
                    wr_addr = cnt_reg[IDX_W-1:0];
                    wr_data = reduced;
                end
                if (cnt_reg == '0) begin
                    last_next  = reduced;
                    state_next = ST_DRAW_MUL;
                end else begin
                    cnt_next   = cnt_reg - CNT_ONE;
                    state_next = ST_WARM_MUL;
                end
            end
            ST_DRAW_MUL: begin
                prod_next  = 46'(lcg_reg) * 46'(srg_pkg::LCG_MUL);
                q0_next    = recip_prod[46:40];
                state_next = ST_DRAW_RED;
            end
            ST_DRAW_RED: begin
                lcg_next   = reduced;
                qd_next    = 31'(38'(q0_reg) * 38'(DIV_C));
                state_next = ST_DRAW_IDX;
            end
            ST_DRAW_IDX: begin
                idx_next   = idx_sel;
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                if (!out_valid_reg || m_ready) begin
                    wr_en          = 1'b1;
                    last_next      = rd_data_reg;
                    out_valid_next = 1'b1;
                    sat_next       = (rd_data_reg > srg_pkg::SAT_LIMIT);
                    sample_next    = (rd_data_reg > srg_pkg::SAT_LIMIT)
                                     ? srg_pkg::SAT_LIMIT : rd_data_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (state_reg == ST_DRAW_IDX) begin
            rd_data_reg <= table_mem[idx_sel];
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        lcg_reg    <= lcg_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        q0_reg     <= q0_next;
        qd_reg     <= qd_next;
        idx_reg    <= idx_next;
        sample_reg <= sample_next;
        sat_reg    <= sat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/shuffled_lcg_random_generator.sv]
// ----------------------------------------------------------------------------
// shuffled_lcg_random_generator
// Minimal-standard generator behind a Bays-Durham shuffle table.
//
// Each request on s_valid/s_ready (field s_reseed) returns one result on
// m_valid/m_ready (m_sample, m_saturated). m_sample is a numerator over
// 2^31-1, clipped at 2147483389 with m_saturated set when clipped.
// cfg_valid/cfg_ready writes the seed register (cfg_ready is always high).
// A plain draw takes the back end through idle pickup, multiply, reduce,
// index divide and table read/write; the table memory port and the
// multiply-mod unit set these steps. A reseed request, and the first
// request after reset, first runs TABLE_ENTRIES + 8 warm-up steps, each a
// multiply state and a reduce state. Reset clears the control state and
// loads seed 123456; the first request then warms up from 1 unless it
// reseeds. When m_ready is low the result is held and the back end waits
// at its write step; the two-entry queue keeps taking requests until it
// is full.
// ----------------------------------------------------------------------------
module shuffled_lcg_random_generator #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_seed_value,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_reseed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_sample,
    output logic        m_saturated
);

    `include "shuffled_lcg_random_generator_assert.svh"

    logic [30:0]     seed_reg;
    logic [30:0]     seed_next;
    logic            push_valid;
    logic            push_ready;
    srg_pkg::req_t   push_data;
    logic            pop_valid;
    logic            pop_ready;
    srg_pkg::req_t   pop_data;
    srg_pkg::qstat_t q_status;
    logic            back_busy;

    assign cfg_ready = 1'b1;
    assign seed_next = (cfg_valid && cfg_ready) ? cfg_seed_value : seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 31'd123456;
        end else begin
            seed_reg <= seed_next;
        end
    end

    srg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_reseed   (s_reseed),
        .seed_value (seed_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    srg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data),
        .status    (q_status)
    );

    srg_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (pop_valid),
        .req_ready   (pop_ready),
        .req_data    (pop_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample    (m_sample),
        .m_saturated (m_saturated),
        .busy        (back_busy)
    );

    `SRG_ASSERT_NEXT(a_accept_queued, s_valid && s_ready, !q_status.empty)
    `SRG_ASSERT_IMPL(a_result_from_back, $rose(m_valid), $past(back_busy))
    `SRG_ASSERT_IMPL(a_stall_only_full, !s_ready, q_status.full)
    `SRG_ASSERT_IMPL(a_sat_clip, m_valid && m_saturated, m_sample == srg_pkg::SAT_LIMIT)

endmodule
